// File: design/bpf_pkg.sv
`default_nettype none
package bpf_pkg;

  typedef enum logic [1:0] {
    ACT_OPEN  = 2'd0,
    ACT_CLOSE = 2'd1,
    ACT_PUT   = 2'd2,
    ACT_GET   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_WAIT      = 3'd2,
    STAT_EOS       = 3'd3,
    STAT_UNDERFLOW = 3'd4,
    STAT_SATURATE  = 3'd5
  } status_t;

  localparam logic [7:0] WRITERS_MAX = 8'd255;

  // controller -> datapath
  typedef struct packed {
    logic exec;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic get_hit;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: design/bpf_ifs.sv
`default_nettype none
interface bpf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] write_byte;

  modport source (output valid, output action, output write_byte, input ready);
  modport sink   (input valid, input action, input write_byte, output ready);
endinterface

interface bpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic [2:0] status;
  logic [7:0] writer_count;

  modport source (output valid, output read_byte, output status, output writer_count,
                  input ready);
  modport sink   (input valid, input read_byte, input status, input writer_count,
                  output ready);
endinterface
`default_nettype wire

// File: design/bpf_ram.sv
`default_nettype none
module bpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/bpf_dp.sv
`default_nettype none
module bpf_dp #(
  parameter int DEPTH = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bpf_pkg::dp_cmd_t  cmd,
  output bpf_pkg::dp_sts_t       sts,
  input  wire logic [1:0]        action,
  input  wire logic [7:0]        write_byte,
  output logic      [7:0]        read_byte,
  output logic      [2:0]        status,
  output logic      [7:0]        writer_count
);
  import bpf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [PW-1:0] ONE  = PW'(1);

  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [7:0]    writers_r, writers_nxt;
  logic [2:0]    status_r, status_nxt;
  logic          rd_sel_r, rd_sel_nxt;

  logic [PW-1:0] wp_inc, rp_inc;
  logic          full, empty;
  logic          ram_we, ram_re;
  logic [7:0]    ram_rdata;

  assign wp_inc = (wp_r == LAST) ? '0 : wp_r + ONE;
  assign rp_inc = (rp_r == LAST) ? '0 : rp_r + ONE;
  assign full   = (wp_inc == rp_r);
  assign empty  = (rp_r == wp_r);

  assign sts.get_hit = (action == ACT_GET) && !empty;

  assign ram_we = cmd.exec && (action == ACT_PUT) && !full;
  assign ram_re = cmd.exec && sts.get_hit;

  always_comb begin
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    writers_nxt = writers_r;
    status_nxt  = status_r;
    rd_sel_nxt  = rd_sel_r;
    if (cmd.exec) begin
      status_nxt = STAT_OK;
      rd_sel_nxt = 1'b0;
      case (action)
        ACT_OPEN: begin
          if (writers_r == WRITERS_MAX) begin
            status_nxt = STAT_SATURATE;
          end else begin
            writers_nxt = writers_r + 8'd1;
          end
        end
        ACT_CLOSE: begin
          if (writers_r == 8'd0) begin
            status_nxt = STAT_UNDERFLOW;
          end else begin
            writers_nxt = writers_r - 8'd1;
          end
        end
        ACT_PUT: begin
          if (full) begin
            status_nxt = STAT_FULL;
          end else begin
            wp_nxt = wp_inc;
          end
        end
        default: begin
          if (empty) begin
            status_nxt = (writers_r == 8'd0) ? STAT_EOS : STAT_WAIT;
          end else begin
            rp_nxt     = rp_inc;
            rd_sel_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      rp_r      <= '0;
      writers_r <= '0;
    end else begin
      wp_r      <= wp_nxt;
      rp_r      <= rp_nxt;
      writers_r <= writers_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rd_sel_r <= rd_sel_nxt;
  end

  bpf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (write_byte),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  // RAM output holds until the next get, so it can drive the result directly
  assign read_byte    = rd_sel_r ? ram_rdata : 8'd0;
  assign status       = status_r;
  assign writer_count = writers_r;

endmodule
`default_nettype wire

// File: design/bpf_ctrl.sv
`default_nettype none
module bpf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bpf_pkg::dp_cmd_t       cmd,
  input  wire bpf_pkg::dp_sts_t  sts
);
  import bpf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign cmd.exec  = in_ready && in_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // a get with data goes through S_READ to wait on the RAM read
          state_nxt = sts.get_hit ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/byte_pipe_fifo_with_writer_count_top.sv
// Byte FIFO with a count of open writers and end-of-stream reporting.
// in_chan carries one transaction per action: open writer, close writer,
// put byte or get byte. out_chan returns exactly one result transaction per
// action: the byte read (zero unless a get succeeded), a status code and the
// writer count after the action. A full put or an empty get changes nothing.
// The store holds DEPTH slots, at most DEPTH-1 bytes, in one RAM with a
// registered read port.
// The result is registered: it is valid in S_DONE after acceptance, and a get
// that returns data passes through S_READ first (RAM read). One transaction
// is in flight at a time; in_chan.ready stays low until the pending result
// is taken, and a stalled receiver holds the result and its payload stable.
// Reset (synchronous, active low) empties the FIFO and clears the writer
// count; RAM contents are not cleared, and no slot is read before written.
`default_nettype none
module byte_pipe_fifo_with_writer_count_top #(
  parameter int DEPTH = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bpf_in_if.sink     in_chan,
  bpf_out_if.source  out_chan
);
  import bpf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bpf_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .action       (in_chan.action),
    .write_byte   (in_chan.write_byte),
    .read_byte    (out_chan.read_byte),
    .status       (out_chan.status),
    .writer_count (out_chan.writer_count)
  );

endmodule
`default_nettype wire

// File: design/bpf_checker.sv
`default_nettype none
module bpf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] read_byte,
  input wire logic [2:0] status,
  input wire logic [7:0] writer_count
);
  import bpf_pkg::*;

  // one transaction in flight: no new accept right after one
  a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in flight");

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  a_byte_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (status != STAT_OK)) |-> (read_byte == 8'd0))
    else $error("nonzero read byte on a failed action");

  a_eos_no_writers: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (status == STAT_EOS)) |-> (writer_count == 8'd0))
    else $error("end of stream reported with open writers");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(read_byte) && $stable(status) && $stable(writer_count)))
    else $error("stalled result changed");

endmodule

bind byte_pipe_fifo_with_writer_count_top bpf_checker u_bpf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .read_byte    (out_chan.read_byte),
  .status       (out_chan.status),
  .writer_count (out_chan.writer_count)
);
`default_nettype wire
